FILE: design/swhsr_pkg.sv
// Shared types and constants for the single-wire humidity sensor reader.
package swhsr_pkg;

    // Number of data bits in one sensor frame.
    localparam int unsigned FRAME_BITS = 40;

    // Widths of the configuration port and the internal counters.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned TIMER_W    = 16;
    localparam int unsigned LIMIT_W    = 10;
    localparam int unsigned THRESH_W   = 8;
    localparam int unsigned BITCNT_W   = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_LIM    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_THRESH = 3'd4;

    // Configuration reset values.
    localparam logic [TIMER_W-1:0]  RST_START_LOW  = 16'd10000;
    localparam logic [LIMIT_W-1:0]  RST_ACK_WAIT   = 10'd100;
    localparam logic [LIMIT_W-1:0]  RST_PHASE_LIM  = 10'd100;
    localparam logic [LIMIT_W-1:0]  RST_BIT_LIM    = 10'd100;
    localparam logic [THRESH_W-1:0] RST_ONE_THRESH = 8'd50;

    // Completion status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_SUM     = 2'd2
    } t_status;

    // Protocol phases, one-hot.
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_START    = 7'b0000010,
        PH_ACK_LOW  = 7'b0000100,
        PH_ACK_HIGH = 7'b0001000,
        PH_ACK_END  = 7'b0010000,
        PH_BIT_LOW  = 7'b0100000,
        PH_BIT_HIGH = 7'b1000000
    } t_phase;

endpackage

FILE: design/single_wire_humidity_sensor_reader_top.sv
// Top level of the single-wire humidity sensor reader: tick sequencer and result register.
//
//  Channel   Handshake                 Payload
//  -------   -----------------------   ------------------------------------------------
//  input     i_in_valid / o_in_ready   i_start_req, i_line_level
//  result    o_out_valid / i_out_ready o_drive_low, o_busy_res, o_done_res, o_status,
//                                      o_humidity_tenths, o_temp_tenths
//  config    i_cfg_we                  i_cfg_index, i_cfg_data
//
// Each accepted tick is processed combinationally; its result sits in the output register
// on the next cycle, and one tick can be accepted every cycle unless the result stalls.
// The single result register sets the figure: a new tick is taken whenever that register
// is empty or is being emptied in the same cycle.
// Reset is synchronous and active low; it restores the configuration defaults, the idle
// phase and zero readings. A stalled result holds the input off until it is taken.
module single_wire_humidity_sensor_reader_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Tick input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_start_req,
    input  logic                                i_line_level,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_drive_low,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic [1:0]                          o_status,
    output logic [15:0]                         o_humidity_tenths,
    output logic signed [15:0]                  o_temp_tenths,
    // Configuration write port
    input  logic                                i_cfg_we,
    input  logic [swhsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    // Configuration registers
    logic [swhsr_pkg::TIMER_W-1:0]  r_start_low;
    logic [swhsr_pkg::LIMIT_W-1:0]  r_ack_wait;
    logic [swhsr_pkg::LIMIT_W-1:0]  r_phase_lim;
    logic [swhsr_pkg::LIMIT_W-1:0]  r_bit_lim;
    logic [swhsr_pkg::THRESH_W-1:0] r_one_thresh;

    // Sequencer state
    swhsr_pkg::t_phase                   r_phase, n_phase;
    logic [swhsr_pkg::TIMER_W-1:0]       r_timer, n_timer;
    logic [swhsr_pkg::BITCNT_W-1:0]      r_bit_count, n_bit_count;
    logic [swhsr_pkg::FRAME_BITS-1:0]    r_frame, n_frame;
    logic [15:0]                         r_hum, n_hum;
    logic [15:0]                         r_temp, n_temp;

    // Result register
    logic                  r_out_valid;
    logic                  r_drive_low, n_drive_low;
    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    swhsr_pkg::t_status    r_status, n_status;

    // Working values
    logic                           accept;
    logic [swhsr_pkg::TIMER_W-1:0]  timer_inc;
    logic [7:0]                     b0, b1, b2, b3, b4;
    logic [7:0]                     byte_sum;
    logic [15:0]                    mag;
    logic                           bit_val;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign timer_inc  = r_timer + 16'd1;
    assign bit_val    = (r_timer > {8'd0, r_one_thresh});

    // Frame bytes as they will stand once the current bit is shifted in.
    assign n_frame = {r_frame[swhsr_pkg::FRAME_BITS-2:0], bit_val};
    assign b0 = n_frame[39:32];
    assign b1 = n_frame[31:24];
    assign b2 = n_frame[23:16];
    assign b3 = n_frame[15:8];
    assign b4 = n_frame[7:0];
    assign byte_sum = b0 + b1 + b2 + b3;
    assign mag = {1'b0, b2[6:0], b3};

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_low  <= swhsr_pkg::RST_START_LOW;
            r_ack_wait   <= swhsr_pkg::RST_ACK_WAIT;
            r_phase_lim  <= swhsr_pkg::RST_PHASE_LIM;
            r_bit_lim    <= swhsr_pkg::RST_BIT_LIM;
            r_one_thresh <= swhsr_pkg::RST_ONE_THRESH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                swhsr_pkg::CFG_START_LOW:  r_start_low  <= i_cfg_data;
                swhsr_pkg::CFG_ACK_WAIT:   r_ack_wait   <= i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                swhsr_pkg::CFG_PHASE_LIM:  r_phase_lim  <= i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                swhsr_pkg::CFG_BIT_LIM:    r_bit_lim    <= i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                swhsr_pkg::CFG_ONE_THRESH: r_one_thresh <= i_cfg_data[swhsr_pkg::THRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Next state for one tick.
    always_comb begin
        n_phase     = r_phase;
        n_timer     = r_timer;
        n_bit_count = r_bit_count;
        n_hum       = r_hum;
        n_temp      = r_temp;
        n_done      = 1'b0;
        n_status    = swhsr_pkg::ST_OK;
        case (r_phase)
            swhsr_pkg::PH_IDLE: begin
                if (i_start_req) begin
                    n_phase = swhsr_pkg::PH_START;
                    n_timer = '0;
                end
            end
            swhsr_pkg::PH_START: begin
                n_timer = timer_inc;
                if (timer_inc >= r_start_low) begin
                    n_phase = swhsr_pkg::PH_ACK_LOW;
                    n_timer = '0;
                end
            end
            swhsr_pkg::PH_ACK_LOW: begin
                if (!i_line_level) begin
                    n_phase = swhsr_pkg::PH_ACK_HIGH;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {6'd0, r_ack_wait}) begin
                        n_done   = 1'b1;
                        n_status = swhsr_pkg::ST_TIMEOUT;
                    end
                end
            end
            swhsr_pkg::PH_ACK_HIGH: begin
                if (i_line_level) begin
                    n_phase = swhsr_pkg::PH_ACK_END;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {6'd0, r_phase_lim}) begin
                        n_done   = 1'b1;
                        n_status = swhsr_pkg::ST_TIMEOUT;
                    end
                end
            end
            swhsr_pkg::PH_ACK_END: begin
                if (!i_line_level) begin
                    n_phase     = swhsr_pkg::PH_BIT_LOW;
                    n_timer     = '0;
                    n_bit_count = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {6'd0, r_phase_lim}) begin
                        n_done   = 1'b1;
                        n_status = swhsr_pkg::ST_TIMEOUT;
                    end
                end
            end
            swhsr_pkg::PH_BIT_LOW: begin
                if (i_line_level) begin
                    n_phase = swhsr_pkg::PH_BIT_HIGH;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {6'd0, r_phase_lim}) begin
                        n_done   = 1'b1;
                        n_status = swhsr_pkg::ST_TIMEOUT;
                    end
                end
            end
            swhsr_pkg::PH_BIT_HIGH: begin
                if (!i_line_level) begin
                    n_bit_count = r_bit_count + 6'd1;
                    n_timer     = '0;
                    if (n_bit_count >= swhsr_pkg::BITCNT_W'(swhsr_pkg::FRAME_BITS)) begin
                        n_done = 1'b1;
                        // Checksum over the first four bytes against the fifth.
                        if (byte_sum != b4) begin
                            n_status = swhsr_pkg::ST_SUM;
                        end else begin
                            n_hum  = {b0, b1};
                            n_temp = b2[7] ? (16'd0 - mag) : mag;
                        end
                    end else begin
                        n_phase = swhsr_pkg::PH_BIT_LOW;
                    end
                end else begin
                    n_timer = timer_inc;
                    if (timer_inc >= {6'd0, r_bit_lim}) begin
                        n_done   = 1'b1;
                        n_status = swhsr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
                n_phase = swhsr_pkg::PH_IDLE;
            end
        endcase
        if (n_done) begin
            n_phase = swhsr_pkg::PH_IDLE;
            n_timer = '0;
        end
        n_drive_low = (n_phase == swhsr_pkg::PH_START);
        n_busy      = (n_phase != swhsr_pkg::PH_IDLE);
    end

    // Sequencer state and held readings advance on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= swhsr_pkg::PH_IDLE;
            r_timer     <= '0;
            r_bit_count <= '0;
            r_frame     <= '0;
            r_hum       <= '0;
            r_temp      <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_timer     <= n_timer;
            r_bit_count <= n_bit_count;
            r_hum       <= n_hum;
            r_temp      <= n_temp;
            // The frame clears when data starts and shifts on each falling edge of a bit.
            if (r_phase == swhsr_pkg::PH_ACK_END && !i_line_level) begin
                r_frame <= '0;
            end else if (r_phase == swhsr_pkg::PH_BIT_HIGH && !i_line_level) begin
                r_frame <= n_frame;
            end
        end
    end

    // Result register: loaded on accept, emptied when the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drive_low <= n_drive_low;
            r_busy      <= n_busy;
            r_done      <= n_done;
            r_status    <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_drive_low       = r_drive_low;
    assign o_busy_res        = r_busy;
    assign o_done_res        = r_done;
    assign o_status          = r_status;
    assign o_humidity_tenths = r_hum;
    assign o_temp_tenths     = $signed(r_temp);

    // A finished read reports the block as no longer busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> !o_busy_res)
        else $error("done reported while still busy");

    // The start pulse only occurs within a read.
    a_drive_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_drive_low) |-> o_busy_res)
        else $error("line driven low outside a read");

    // Status is only non-zero together with done.
    a_status_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_done_res) |-> (o_status == swhsr_pkg::ST_OK))
        else $error("status set without done");

    // The bit counter never runs past one frame.
    a_bit_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count <= swhsr_pkg::BITCNT_W'(swhsr_pkg::FRAME_BITS))
        else $error("bit counter beyond frame length");

    // An empty result register never holds off the input.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for the single-wire humidity sensor reader: a sensor model and a predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int RANDOM_TICKS = 400;
    localparam int CALM_TICKS   = 150;
    localparam int N_ROWS       = 13;

    // Ways in which the sensor model can spoil a read.
    typedef enum logic [2:0] {
        F_NONE,
        F_SUM,
        F_TO_ACK_LOW,
        F_TO_ACK_HIGH,
        F_TO_ACK_END,
        F_TO_BIT_LOW,
        F_TO_BIT_HIGH
    } t_fault;

    // One result item of the block.
    typedef struct packed {
        logic               drive_low;
        logic               busy;
        logic               done;
        swhsr_pkg::t_status status;
        logic [15:0]        hum;
        logic [15:0]        temp;
    } t_reading;

    // One directed read: timing to load, frame content, fault and, where set, the outcome.
    typedef struct packed {
        logic               load;
        logic [15:0]        start_low;
        logic [9:0]         ack_wait;
        logic [9:0]         phase_lim;
        logic [9:0]         bit_lim;
        logic [7:0]         thresh;
        logic [15:0]        hum;
        logic [15:0]        temp_raw;
        t_fault             fault;
        logic               checked;
        swhsr_pkg::t_status exp_status;
        logic [15:0]        exp_hum;
        logic [15:0]        exp_temp;
    } t_scenario;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic                             i_start_req;
    logic                             i_line_level;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic                             o_drive_low;
    logic                             o_busy_res;
    logic                             o_done_res;
    logic [1:0]                       o_status;
    logic [15:0]                      o_humidity_tenths;
    logic signed [15:0]               o_temp_tenths;
    logic                             i_cfg_we;
    logic [swhsr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [swhsr_pkg::CFG_DATA_W-1:0] i_cfg_data;

    single_wire_humidity_sensor_reader_top DUT (.*);

    // Predictor state and its copy of the timing registers.
    swhsr_pkg::t_phase fsm_phase;
    logic [15:0]   fsm_timer;
    logic [5:0]    fsm_bits;
    logic [39:0]   fsm_frame;
    logic [15:0]   hum_hold;
    logic [15:0]   temp_hold;
    logic [15:0]   cfg_start_low;
    logic [9:0]    cfg_ack_wait;
    logic [9:0]    cfg_phase_lim;
    logic [9:0]    cfg_bit_lim;
    logic [7:0]    cfg_one_thresh;

    t_reading      pending_readings[$];
    t_reading      last_done;
    int            mismatches  = 0;
    int            ticks_sent  = 0;
    int            calm_from   = 32'h7FFF_0000;
    int            cycle_count = 0;
    bit            steady      = 1'b0;

    // Directed reads. Rows three to ten keep the timing of row two.
    t_scenario plan [N_ROWS] = '{
        // Wait limits at their reset values: the acknowledge times out, readings still zero.
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'd652, 16'h0161, F_TO_ACK_LOW,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0000, 16'h0000},
        // Shortest start signal; largest humidity and temperature.
        '{1'b1, 16'd0, 10'd1, 10'd1, 10'd3, 8'd1, 16'hFFFF, 16'h7FFF, F_NONE,
          1'b1, swhsr_pkg::ST_OK, 16'hFFFF, 16'd32767},
        // Most negative temperature.
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h0000, 16'hFFFF, F_NONE,
          1'b1, swhsr_pkg::ST_OK, 16'h0000, -16'sd32767},
        // Sign bit set with a zero magnitude.
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h0001, 16'h8000, F_NONE,
          1'b1, swhsr_pkg::ST_OK, 16'h0001, 16'h0000},
        // Bad checksum leaves the readings alone.
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'd100, 16'd200, F_SUM,
          1'b1, swhsr_pkg::ST_SUM, 16'h0001, 16'h0000},
        // A timeout in each wait.
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h1111, 16'h1111, F_TO_ACK_LOW,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0001, 16'h0000},
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h1111, 16'h1111, F_TO_ACK_HIGH,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0001, 16'h0000},
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h1111, 16'h1111, F_TO_ACK_END,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0001, 16'h0000},
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h1111, 16'h1111, F_TO_BIT_LOW,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0001, 16'h0000},
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h1111, 16'h1111, F_TO_BIT_HIGH,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'h0001, 16'h0000},
        // Smallest limits and threshold.
        '{1'b1, 16'd1, 10'd1, 10'd1, 10'd1, 8'd1, 16'h0000, 16'h0000, F_NONE,
          1'b1, swhsr_pkg::ST_OK, 16'h0000, 16'h0000},
        // Longer limits and a higher threshold.
        '{1'b1, 16'd2, 10'd5, 10'd5, 10'd7, 8'd3, 16'hA55A, 16'h5AA5, F_NONE,
          1'b0, swhsr_pkg::ST_OK, 16'h0000, 16'h0000},
        '{1'b0, 16'd0, 10'd0, 10'd0, 10'd0, 8'd0, 16'h2222, 16'h2222, F_TO_ACK_LOW,
          1'b1, swhsr_pkg::ST_TIMEOUT, 16'hA55A, 16'h5AA5}
    };

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Guard against a hang.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached", $time);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // True when a side should sit out this cycle.
    function automatic bit take_break();
        return !steady && ($urandom_range(0, 99) < 26);
    endfunction

    // A start request while busy must be ignored, so offer one now and then.
    function automatic logic busy_start();
        return ($urandom_range(0, 3) == 0);
    endfunction

    // Result channel back-pressure.
    always @(negedge i_clk) begin
        i_out_ready <= !take_break();
    end

    // One tick of a wait: count it and report whether the limit has been reached.
    function automatic logic timer_expired(input logic [15:0] limit);
        fsm_timer = fsm_timer + 16'd1;
        return fsm_timer >= limit;
    endfunction

    // Advance the predicted reader by one tick and give the result item it shows.
    task automatic predict_reading(input logic start, input logic level, output t_reading r);
        logic               finished;
        swhsr_pkg::t_status outcome;
        logic [7:0]         b0, b1, b2, b3, b4, sum;
        logic [14:0]        mag;
        finished = 1'b0;
        outcome  = swhsr_pkg::ST_OK;
        case (fsm_phase)
            swhsr_pkg::PH_IDLE: begin
                if (start) begin
                    fsm_phase = swhsr_pkg::PH_START;
                    fsm_timer = '0;
                end
            end
            swhsr_pkg::PH_START: begin
                fsm_timer = fsm_timer + 16'd1;
                if (fsm_timer >= cfg_start_low) begin
                    fsm_phase = swhsr_pkg::PH_ACK_LOW;
                    fsm_timer = '0;
                end
            end
            swhsr_pkg::PH_ACK_LOW: begin
                if (!level) begin
                    fsm_phase = swhsr_pkg::PH_ACK_HIGH;
                    fsm_timer = '0;
                end else if (timer_expired(16'(cfg_ack_wait))) begin
                    finished = 1'b1;
                    outcome  = swhsr_pkg::ST_TIMEOUT;
                end
            end
            swhsr_pkg::PH_ACK_HIGH: begin
                if (level) begin
                    fsm_phase = swhsr_pkg::PH_ACK_END;
                    fsm_timer = '0;
                end else if (timer_expired(16'(cfg_phase_lim))) begin
                    finished = 1'b1;
                    outcome  = swhsr_pkg::ST_TIMEOUT;
                end
            end
            swhsr_pkg::PH_ACK_END: begin
                if (!level) begin
                    fsm_phase = swhsr_pkg::PH_BIT_LOW;
                    fsm_timer = '0;
                    fsm_bits  = '0;
                    fsm_frame = '0;
                end else if (timer_expired(16'(cfg_phase_lim))) begin
                    finished = 1'b1;
                    outcome  = swhsr_pkg::ST_TIMEOUT;
                end
            end
            swhsr_pkg::PH_BIT_LOW: begin
                if (level) begin
                    fsm_phase = swhsr_pkg::PH_BIT_HIGH;
                    fsm_timer = '0;
                end else if (timer_expired(16'(cfg_phase_lim))) begin
                    finished = 1'b1;
                    outcome  = swhsr_pkg::ST_TIMEOUT;
                end
            end
            swhsr_pkg::PH_BIT_HIGH: begin
                if (!level) begin
                    // Falling edge: the pulse width decides the bit.
                    fsm_frame = {fsm_frame[38:0], fsm_timer > 16'(cfg_one_thresh)};
                    fsm_bits  = fsm_bits + 6'd1;
                    fsm_timer = '0;
                    if (fsm_bits >= swhsr_pkg::FRAME_BITS) begin
                        finished = 1'b1;
                        {b0, b1, b2, b3, b4} = fsm_frame;
                        sum = b0 + b1 + b2 + b3;
                        if (sum != b4) begin
                            outcome = swhsr_pkg::ST_SUM;
                        end else begin
                            // Temperature arrives as sign and magnitude.
                            hum_hold  = {b0, b1};
                            mag       = {b2[6:0], b3};
                            temp_hold = b2[7] ? 16'd0 - {1'b0, mag} : {1'b0, mag};
                            outcome   = swhsr_pkg::ST_OK;
                        end
                    end else begin
                        fsm_phase = swhsr_pkg::PH_BIT_LOW;
                    end
                end else if (timer_expired(16'(cfg_bit_lim))) begin
                    finished = 1'b1;
                    outcome  = swhsr_pkg::ST_TIMEOUT;
                end
            end
            default: fsm_phase = swhsr_pkg::PH_IDLE;
        endcase
        if (finished) begin
            fsm_phase = swhsr_pkg::PH_IDLE;
            fsm_timer = '0;
        end
        r.drive_low = (fsm_phase == swhsr_pkg::PH_START);
        r.busy      = (fsm_phase != swhsr_pkg::PH_IDLE);
        r.done      = finished;
        r.status    = finished ? outcome : swhsr_pkg::ST_OK;
        r.hum       = hum_hold;
        r.temp      = temp_hold;
    endtask

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    // Predict accepted ticks, compare accepted results and follow register writes.
    always @(posedge i_clk) begin : monitor
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            fsm_phase      = swhsr_pkg::PH_IDLE;
            fsm_timer      = '0;
            fsm_bits       = '0;
            fsm_frame      = '0;
            hum_hold       = '0;
            temp_hold      = '0;
            cfg_start_low  = swhsr_pkg::RST_START_LOW;
            cfg_ack_wait   = swhsr_pkg::RST_ACK_WAIT;
            cfg_phase_lim  = swhsr_pkg::RST_PHASE_LIM;
            cfg_bit_lim    = swhsr_pkg::RST_BIT_LIM;
            cfg_one_thresh = swhsr_pkg::RST_ONE_THRESH;
            pending_readings.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_drive_low, o_busy_res, o_done_res, swhsr_pkg::t_status'(o_status),
                        o_humidity_tenths, o_temp_tenths};
                if (pending_readings.size() == 0) begin
                    $display("%0t: result item with nothing expected: expected none, got %0h",
                             $time, got);
                    mismatches++;
                end else begin
                    want = pending_readings.pop_front();
                    check_field("drive_low", 16'(want.drive_low), 16'(got.drive_low));
                    check_field("busy", 16'(want.busy), 16'(got.busy));
                    check_field("done", 16'(want.done), 16'(got.done));
                    check_field("status", 16'(want.status), 16'(got.status));
                    check_field("humidity", want.hum, got.hum);
                    check_field("temperature", want.temp, got.temp);
                end
                if (o_done_res) begin
                    last_done = got;
                end
            end
            if (i_in_valid && o_in_ready) begin
                predict_reading(i_start_req, i_line_level, want);
                pending_readings.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    swhsr_pkg::CFG_START_LOW:
                        cfg_start_low  = i_cfg_data;
                    swhsr_pkg::CFG_ACK_WAIT:
                        cfg_ack_wait   = i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                    swhsr_pkg::CFG_PHASE_LIM:
                        cfg_phase_lim  = i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                    swhsr_pkg::CFG_BIT_LIM:
                        cfg_bit_lim    = i_cfg_data[swhsr_pkg::LIMIT_W-1:0];
                    swhsr_pkg::CFG_ONE_THRESH:
                        cfg_one_thresh = i_cfg_data[swhsr_pkg::THRESH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Offer one tick item; called at a falling edge, returns at the falling edge after
    // the item has been taken.
    task automatic send_tick(input logic start, input logic level);
        while (take_break()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_start_req  <= start;
        i_line_level <= level;
        ticks_sent++;
        steady = (ticks_sent >= calm_from) && (ticks_sent < calm_from + CALM_TICKS);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic hold_level(input logic level, input int n);
        repeat (n) send_tick(busy_start(), level);
    endtask

    // Ticks spent in a wait short of its limit, now and then right at the edge.
    function automatic int pick_wait(input int limit);
        if (limit <= 1) return 0;
        if ($urandom_range(0, 7) == 0) return limit - 1;
        return $urandom_range(0, (limit - 1 < 2) ? limit - 1 : 2);
    endfunction

    // Counted width of a bit's high pulse, often right at the threshold.
    function automatic int pick_width(input logic one);
        int t;
        int bl;
        int top;
        t  = cfg_one_thresh;
        bl = cfg_bit_lim;
        if (one) begin
            if (t + 1 > bl - 1) return bl - 1;
            if ($urandom_range(0, 1) == 0) return t + 1;
            top = (bl - 1 < t + 5) ? bl - 1 : t + 5;
            return $urandom_range(t + 1, top);
        end
        top = (t < bl - 1) ? t : bl - 1;
        if ($urandom_range(0, 1) == 0) return top;
        return $urandom_range(0, top);
    endfunction

    function automatic logic [39:0] make_frame(input logic [15:0] hum, input logic [15:0] raw);
        logic [7:0] sum;
        sum = hum[15:8] + hum[7:0] + raw[15:8] + raw[7:0];
        return {hum, raw, sum};
    endfunction

    // Stop offering ticks and wait until every expected result has arrived.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_readings.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [swhsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
    endtask

    // Load all timing registers while idle; unused upper bits carry junk that must be
    // masked, and an unmapped index is written too.
    task automatic load_timing(input logic [15:0] start_low, input logic [9:0] ack_wait,
                               input logic [9:0] phase_lim, input logic [9:0] bit_lim,
                               input logic [7:0] thresh);
        settle();
        write_reg(swhsr_pkg::CFG_START_LOW, start_low);
        write_reg(swhsr_pkg::CFG_ACK_WAIT, {6'($urandom), ack_wait});
        write_reg(swhsr_pkg::CFG_PHASE_LIM, {6'($urandom), phase_lim});
        write_reg(swhsr_pkg::CFG_BIT_LIM, {6'($urandom), bit_lim});
        write_reg(swhsr_pkg::CFG_ONE_THRESH, {8'($urandom), thresh});
        write_reg(swhsr_pkg::CFG_ONE_THRESH + 3'($urandom_range(1, 3)), 16'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    // Play the sensor's side of one read, optionally spoiling it.
    task automatic run_read(input logic [39:0] frame, input t_fault fault);
        int fail_bit;
        fail_bit = $urandom_range(0, swhsr_pkg::FRAME_BITS - 1);
        if (fault == F_SUM) begin
            frame[7:0] = frame[7:0] ^ 8'($urandom_range(1, 255));
        end
        // Let any unfinished read run into a timeout first.
        while (fsm_phase != swhsr_pkg::PH_IDLE) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'($urandom_range(0, 1)));
        // The line is not looked at while the start signal is driven.
        repeat ((cfg_start_low == 0) ? 1 : int'(cfg_start_low)) begin
            send_tick(busy_start(), 1'($urandom_range(0, 1)));
        end
        if (fault == F_TO_ACK_LOW) begin
            hold_level(1'b1, cfg_ack_wait);
            return;
        end
        hold_level(1'b1, pick_wait(cfg_ack_wait));
        send_tick(busy_start(), 1'b0);
        if (fault == F_TO_ACK_HIGH) begin
            hold_level(1'b0, cfg_phase_lim);
            return;
        end
        hold_level(1'b0, pick_wait(cfg_phase_lim));
        send_tick(busy_start(), 1'b1);
        if (fault == F_TO_ACK_END) begin
            hold_level(1'b1, cfg_phase_lim);
            return;
        end
        hold_level(1'b1, pick_wait(cfg_phase_lim));
        send_tick(busy_start(), 1'b0);
        // Data bits, most significant first.
        for (int i = swhsr_pkg::FRAME_BITS - 1; i >= 0; i--) begin
            if (fault == F_TO_BIT_LOW && i == fail_bit) begin
                hold_level(1'b0, cfg_phase_lim);
                return;
            end
            hold_level(1'b0, pick_wait(cfg_phase_lim));
            send_tick(busy_start(), 1'b1);
            if (fault == F_TO_BIT_HIGH && i == fail_bit) begin
                hold_level(1'b1, cfg_bit_lim);
                return;
            end
            hold_level(1'b1, pick_width(frame[i]));
            send_tick(busy_start(), 1'b0);
        end
    endtask

    task automatic check_outcome(input t_scenario row);
        check_field("final status", 16'(row.exp_status), 16'(last_done.status));
        check_field("final humidity", row.exp_hum, last_done.hum);
        check_field("final temperature", row.exp_temp, last_done.temp);
    endtask

    // Reset, directed reads, then random reads under changing timing.
    initial begin
        int          random_base;
        int          reads;
        int          kind;
        int          thresh;
        logic [15:0] hum;
        logic [15:0] raw;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_start_req  = 1'b0;
        i_line_level = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Shorten the start signal only; the wait limits keep their reset values.
        write_reg(swhsr_pkg::CFG_START_LOW, 16'd1);
        i_cfg_we <= 1'b0;

        for (int r = 0; r < N_ROWS; r++) begin
            if (plan[r].load) begin
                load_timing(plan[r].start_low, plan[r].ack_wait, plan[r].phase_lim,
                            plan[r].bit_lim, plan[r].thresh);
            end
            run_read(make_frame(plan[r].hum, plan[r].temp_raw), plan[r].fault);
            if (plan[r].checked) begin
                settle();
                check_outcome(plan[r]);
            end
        end

        random_base = ticks_sent;
        calm_from   = ticks_sent + CALM_TICKS;
        reads       = 0;
        while (ticks_sent - random_base < RANDOM_TICKS) begin
            if (reads % 3 == 0) begin
                thresh = $urandom_range(1, 4);
                load_timing(16'($urandom_range(0, 6)), 10'($urandom_range(1, 8)),
                            10'($urandom_range(1, 8)), 10'(thresh + $urandom_range(2, 6)),
                            8'(thresh));
            end
            kind = $urandom_range(0, 9);
            hum  = 16'($urandom);
            raw  = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
            if (kind < 7) begin
                run_read(make_frame(hum, raw), F_NONE);
            end else if (kind == 7) begin
                run_read(make_frame(hum, raw), F_SUM);
            end else if (kind == 8) begin
                run_read(make_frame(hum, raw),
                         t_fault'($urandom_range(F_TO_ACK_LOW, F_TO_BIT_HIGH)));
            end else begin
                // Line noise with stray start requests.
                repeat ($urandom_range(5, 40)) begin
                    send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
            end
            repeat ($urandom_range(0, 3)) send_tick(1'b0, 1'($urandom_range(0, 1)));
            reads++;
        end

        settle();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
